/* src/wrhp_pkg.sv */
// ----------------------------------------------------------------------------
// wrhp_pkg
// Types and constants for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package wrhp_pkg;

   typedef enum logic [1:0] {
      PH_RIFF    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_PAD     = 2'd3
   } phase_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_INVAL = 2'd1;
   localparam status_type ST_NOSUP = 2'd2;

   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;   // "fmt "
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;   // "data"

   localparam logic [15:0] FMT_PCM = 16'h0001;
   localparam logic [15:0] FMT_EXT = 16'hFFFE;

   localparam logic [31:0] FMT_LEN_MIN     = 32'd16;
   localparam logic [31:0] FMT_LEN_BAD     = 32'd17;
   localparam logic [31:0] FMT_EXT_LEN_MIN = 32'd40;
   localparam logic [15:0] EXT_SIZE_MIN    = 16'd22;

   localparam logic [3:0] RIFF_HDR_BYTES = 4'd12;

   typedef struct packed {
      logic [15:0] channels;
      logic [31:0] rate;
      logic [15:0] bits;
      logic [15:0] align;
      logic [1:0]  code;
   } fmt_rec_type;

   // "RIFF" at bytes 0..3, "WAVE" at bytes 8..11; bytes 4..7 are not checked
   function automatic logic [7:0] riff_magic(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'h52;
         4'd1:    val = 8'h49;
         4'd2:    val = 8'h46;
         4'd3:    val = 8'h46;
         4'd8:    val = 8'h57;
         4'd9:    val = 8'h41;
         4'd10:   val = 8'h56;
         4'd11:   val = 8'h45;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

/* src/wav_riff_header_parser.sv */
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// Byte-stream RIFF/WAVE header parser: checks magic, walks chunks, validates
// the fmt chunk and reports format plus the last data chunk at end of file.
// ----------------------------------------------------------------------------
// Pipeline: a request sits in the input register; the result of the one
//   flagged last_byte then goes into the result register behind rsp_valid.
// Throughput: one request per cycle while req_stall is low; each byte needs
//   a compare, a shift and a counter update in the single stage between
//   the input and result registers.
// Reset: synchronous, active high; clears the parse state and both valids.
//   The parser also returns to its reset state after each last byte.
// ----------------------------------------------------------------------------
module wav_riff_header_parser
   import wrhp_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_rate_hz,
   output logic [15:0] rsp_sample_bits,
   output logic [15:0] rsp_frame_bytes,
   output logic [1:0]  rsp_sample_code,
   output logic [31:0] rsp_data_offset,
   output logic [31:0] rsp_data_length
);

   // position counter saturates at 2^OFFSET_BITS, so its top bit is the
   // "file too long" flag
   localparam int unsigned PW = OFFSET_BITS + 1;

   // ---------------------------------------------------------------- input reg
   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       proceed;
   logic       rsp_valid_ff;

   // a non-last byte never produces a result, so it never waits on rsp_stall
   assign proceed   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proceed;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // ---------------------------------------------------------------- state
   phase_type      phase_ff, phase_in;
   logic [31:0]    pc_ff, pc_in;          // byte count within current phase
   logic [PW-1:0]  pos_ff, pos_in;        // file byte position
   logic [31:0]    tag_ff, tag_in;
   logic [31:0]    len_ff, len_in;
   logic [7:0]     pend_ff [16];          // first 16 bytes of fmt payload
   logic [7:0]     pend_in [16];
   logic [15:0]    ext_ff, ext_in;        // cbSize of extensible fmt
   fmt_rec_type    kfmt_ff, kfmt_in;
   logic [31:0]    koff_ff, koff_in;
   logic [31:0]    klen_ff, klen_in;
   logic [1:0]     seen_ff, seen_in;      // bit0 fmt accepted, bit1 data seen
   status_type     err_ff, err_in;

   // ---------------------------------------------------------------- result reg
   status_type     rsp_status_ff;
   fmt_rec_type    rsp_fmt_ff;
   logic [31:0]    rsp_off_ff;
   logic [31:0]    rsp_len_ff;

   // ---------------------------------------------------------------- fmt capture
   always_comb begin
      pend_in = pend_ff;
      ext_in  = ext_ff;
      if (phase_ff == PH_HEADER && pc_ff[2:0] == 3'd7 && tag_ff == TAG_FMT) begin
         // new fmt chunk: start from a clean slate
         for (int i = 0; i < 16; i++) begin
            pend_in[i] = 8'h00;
         end
         ext_in = 16'h0000;
      end else if (phase_ff == PH_PAYLOAD && tag_ff == TAG_FMT) begin
         if (pc_ff < 32'd16) begin
            pend_in[pc_ff[3:0]] = in_data_ff;
         end else if (pc_ff == 32'd16) begin
            ext_in[7:0] = in_data_ff;
         end else if (pc_ff == 32'd17) begin
            ext_in[15:8] = in_data_ff;
         end
      end
   end

   // fields of the fmt payload as they stand after this byte
   logic [15:0] fmt_word;
   logic [15:0] bits_word;
   logic        bits_ok;
   logic [1:0]  bits_code;

   assign fmt_word  = {pend_in[1], pend_in[0]};
   assign bits_word = {pend_in[15], pend_in[14]};

   always_comb begin
      bits_ok   = 1'b1;
      bits_code = 2'd0;
      case (bits_word)
         16'd8:   bits_code = 2'd0;
         16'd16:  bits_code = 2'd1;
         16'd24:  bits_code = 2'd2;
         16'd32:  bits_code = 2'd3;
         default: bits_ok   = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- main step
   logic [31:0]    pc_inc;
   logic [PW-1:0]  pos_plus1;
   logic [PW+31:0] off_wide;
   logic           end_chunk;
   status_type     step_err;
   status_type     err_a, err_b, err_c;
   logic           final_bad;

   assign pc_inc    = pc_ff + 32'd1;
   assign pos_plus1 = pos_ff + PW'(1);
   assign off_wide  = {32'b0, pos_plus1};

   always_comb begin
      phase_in  = phase_ff;
      pc_in     = pc_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      kfmt_in   = kfmt_ff;
      koff_in   = koff_ff;
      klen_in   = klen_ff;
      seen_in   = seen_ff;
      step_err  = ST_OK;
      end_chunk = 1'b0;

      unique case (phase_ff)
         PH_RIFF: begin
            if ((pc_ff[3:0] < 4'd4 || pc_ff[3:0] >= 4'd8) &&
                in_data_ff != riff_magic(pc_ff[3:0])) begin
               step_err = ST_INVAL;
            end
            pc_in = pc_inc;
            if (pc_inc[3:0] >= RIFF_HDR_BYTES) begin
               phase_in = PH_HEADER;
               pc_in    = 32'd0;
            end
         end
         PH_HEADER: begin
            if (!pc_ff[2]) begin
               // tag, big-endian as it reads
               tag_in = {(pc_ff[1:0] == 2'd0) ? 24'h0 : tag_ff[23:0], in_data_ff};
               if (pc_ff[1:0] == 2'd0) begin
                  len_in = 32'd0;
               end
            end else begin
               // size, little-endian
               len_in = len_ff | ({24'h0, in_data_ff} << {pc_ff[1:0], 3'b000});
            end
            pc_in = pc_inc;
            if (pc_ff[2:0] == 3'd7) begin
               if (tag_ff == TAG_DATA) begin
                  koff_in    = off_wide[31:0];
                  klen_in    = len_in;
                  seen_in[1] = 1'b1;
               end
               phase_in = PH_PAYLOAD;
               pc_in    = 32'd0;
               if (len_in == 32'd0) begin
                  end_chunk = 1'b1;
               end
            end
         end
         PH_PAYLOAD: begin
            pc_in = pc_inc;
            if (pc_inc == len_ff) begin
               end_chunk = 1'b1;
            end
         end
         PH_PAD: begin
            phase_in = PH_HEADER;
            pc_in    = 32'd0;
         end
      endcase

      if (end_chunk) begin
         phase_in = len_in[0] ? PH_PAD : PH_HEADER;
         pc_in    = 32'd0;
         if (tag_in == TAG_FMT) begin
            if (len_in < FMT_LEN_MIN) begin
               step_err = ST_INVAL;
            end else if (len_in > FMT_LEN_MIN &&
                         (len_in == FMT_LEN_BAD ||
                          (fmt_word == FMT_EXT &&
                           (ext_in < EXT_SIZE_MIN || len_in < FMT_EXT_LEN_MIN)))) begin
               step_err = ST_INVAL;
            end else if (fmt_word != FMT_PCM && fmt_word != FMT_EXT) begin
               step_err = ST_NOSUP;
            end else if (!bits_ok) begin
               step_err = ST_NOSUP;
            end else begin
               kfmt_in.channels = {pend_in[3], pend_in[2]};
               kfmt_in.rate     = {pend_in[7], pend_in[6], pend_in[5], pend_in[4]};
               kfmt_in.align    = {pend_in[13], pend_in[12]};
               kfmt_in.bits     = bits_word;
               kfmt_in.code     = bits_code;
               seen_in[0]       = 1'b1;
            end
         end
      end

      // first error sticks: too-long file, then this byte, then end-of-file
      err_a     = (err_ff == ST_OK && pos_ff[OFFSET_BITS]) ? ST_INVAL : err_ff;
      err_b     = (err_a == ST_OK) ? step_err : err_a;
      final_bad = (phase_in == PH_RIFF) || (phase_in == PH_PAYLOAD) || (seen_in != 2'b11);
      err_c     = (err_b == ST_OK && final_bad) ? ST_INVAL : err_b;

      pos_in = pos_ff[OFFSET_BITS] ? pos_ff : pos_plus1;
      err_in = err_b;

      // end of file: back to reset for the next one
      if (in_last_ff) begin
         phase_in = PH_RIFF;
         pc_in    = 32'd0;
         pos_in   = '0;
         seen_in  = 2'b00;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         pc_ff    <= 32'd0;
         pos_ff   <= '0;
         seen_ff  <= 2'b00;
         err_ff   <= ST_OK;
      end else if (proceed) begin
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
         pos_ff   <= pos_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
      end
   end

   // chunk and record payload: only read once seen/phase say it is valid
   always_ff @(posedge clock) begin
      if (proceed) begin
         tag_ff  <= tag_in;
         len_ff  <= len_in;
         pend_ff <= pend_in;
         ext_ff  <= ext_in;
         kfmt_ff <= kfmt_in;
         koff_ff <= koff_in;
         klen_ff <= klen_in;
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proceed && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proceed && in_last_ff) begin
         rsp_status_ff <= err_c;
         if (err_c == ST_OK) begin
            rsp_fmt_ff <= kfmt_in;
            rsp_off_ff <= koff_in;
            rsp_len_ff <= klen_in;
         end else begin
            rsp_fmt_ff <= '0;
            rsp_off_ff <= 32'd0;
            rsp_len_ff <= 32'd0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_channel_count = rsp_fmt_ff.channels;
   assign rsp_rate_hz       = rsp_fmt_ff.rate;
   assign rsp_sample_bits   = rsp_fmt_ff.bits;
   assign rsp_frame_bytes   = rsp_fmt_ff.align;
   assign rsp_sample_code   = rsp_fmt_ff.code;
   assign rsp_data_offset   = rsp_off_ff;
   assign rsp_data_length   = rsp_len_ff;

   // ---------------------------------------------------------------- checks
   // an error result carries nothing but its status
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_fmt_ff == '0 && rsp_data_offset == 32'd0 && rsp_data_length == 32'd0))
      else $error("error result with nonzero fields");

   // the last byte of a file leaves the parser in its reset state
   a_eof_reset: assert property (@(posedge clock) disable iff (reset)
      (proceed && in_last_ff) |=>
         (phase_ff == PH_RIFF && pos_ff == '0 && seen_ff == 2'b00 && err_ff == ST_OK))
      else $error("parser not back at reset state after last byte");

   // a new result is only produced when a last byte goes through
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(proceed && in_last_ff))
      else $error("result without a last byte");

   // a success needs both an accepted fmt and a data chunk at end of file
   a_ok_seen: assert property (@(posedge clock) disable iff (reset)
      (proceed && in_last_ff && err_c == ST_OK) |-> !final_bad)
      else $error("ok status without fmt and data");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wav_riff_header_parser. It streams whole WAV files,
// built at random, through the byte port. A scoreboard runs its own parser
// over every accepted request and holds the summary each file should produce.
// It then checks every result, field by field, against the oldest summary.
// ----------------------------------------------------------------------------
module tb
   import wrhp_pkg::*;
();

   localparam int unsigned OFFSET_BITS = 32;

   // file signature: "RIFF", four unchecked size bytes, "WAVE"
   localparam logic [95:0] RIFF_SIG = 96'h52494646_00000000_57415645;

   // sample encodings reported in rsp_sample_code
   localparam logic [1:0] SC_U8  = 2'd0;
   localparam logic [1:0] SC_S16 = 2'd1;
   localparam logic [1:0] SC_S24 = 2'd2;
   localparam logic [1:0] SC_S32 = 2'd3;

   localparam logic [31:0] TAG_JUNK = 32'h6A75_6E6B;   // "junk"

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_rate_hz;
   logic [15:0] rsp_sample_bits;
   logic [15:0] rsp_frame_bytes;
   logic [1:0]  rsp_sample_code;
   logic [31:0] rsp_data_offset;
   logic [31:0] rsp_data_length;

   wav_riff_header_parser #(.OFFSET_BITS(OFFSET_BITS)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_channel_count (rsp_channel_count),
      .rsp_rate_hz       (rsp_rate_hz),
      .rsp_sample_bits   (rsp_sample_bits),
      .rsp_frame_bytes   (rsp_frame_bytes),
      .rsp_sample_code   (rsp_sample_code),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_data_length   (rsp_data_length)
   );

   // -------------------------------------------------------------------------
   // Scoreboard: byte-level parser plus the queue of file summaries it owes.
   // -------------------------------------------------------------------------
   class wav_scoreboard;
      typedef struct packed {
         status_type  status;
         fmt_rec_type fmt;
         logic [31:0] offset;
         logic [31:0] length;
      } summary_type;

      logic [32:0] position;       // bytes seen in this file, saturating
      phase_type   phase;
      logic [31:0] phase_bytes;
      logic [31:0] tag;
      logic [31:0] size;
      logic [7:0]  fmt_body [16];
      logic [15:0] ext_size;
      fmt_rec_type kept_fmt;
      logic [32:0] kept_offset;
      logic [31:0] kept_length;
      logic        got_fmt;
      logic        got_data;
      status_type  first_err;
      summary_type due [$];
      int          mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         position = '0;
         phase = PH_RIFF;
         phase_bytes = '0;
         tag = '0;
         size = '0;
         foreach (fmt_body[i]) fmt_body[i] = '0;
         ext_size = '0;
         kept_fmt = '0;
         kept_offset = '0;
         kept_length = '0;
         got_fmt = 1'b0;
         got_data = 1'b0;
         first_err = ST_OK;
      endfunction

      function void flag(status_type err);
         if (first_err == ST_OK) first_err = err;
      endfunction

      // fmt payload is judged once the whole chunk has gone by
      function void check_fmt();
         logic [15:0] fmt_code;
         logic [15:0] bits;
         logic [1:0]  code;
         fmt_code = {fmt_body[1], fmt_body[0]};
         bits = {fmt_body[15], fmt_body[14]};
         if (size < FMT_LEN_MIN || size == FMT_LEN_BAD) begin
            flag(ST_INVAL);
            return;
         end
         if (size > FMT_LEN_MIN && fmt_code == FMT_EXT &&
             (ext_size < EXT_SIZE_MIN || size < FMT_EXT_LEN_MIN)) begin
            flag(ST_INVAL);
            return;
         end
         if (fmt_code != FMT_PCM && fmt_code != FMT_EXT) begin
            flag(ST_NOSUP);
            return;
         end
         case (bits)
            16'd8:  code = SC_U8;
            16'd16: code = SC_S16;
            16'd24: code = SC_S24;
            16'd32: code = SC_S32;
            default: begin
               flag(ST_NOSUP);
               return;
            end
         endcase
         kept_fmt.channels = {fmt_body[3], fmt_body[2]};
         kept_fmt.rate = {fmt_body[7], fmt_body[6], fmt_body[5], fmt_body[4]};
         kept_fmt.align = {fmt_body[13], fmt_body[12]};
         kept_fmt.bits = bits;
         kept_fmt.code = code;
         got_fmt = 1'b1;
      endfunction

      function void close_chunk();
         if (tag == TAG_FMT) check_fmt();
         phase = size[0] ? PH_PAD : PH_HEADER;
         phase_bytes = '0;
      endfunction

      function void note_request(logic [7:0] din, logic lst);
         summary_type res;
         if (position >= (33'd1 << OFFSET_BITS)) flag(ST_INVAL);
         case (phase)
            PH_RIFF: begin
               if (phase_bytes < 4 || phase_bytes >= 8) begin
                  if (din != RIFF_SIG[95 - 8 * phase_bytes -: 8]) flag(ST_INVAL);
               end
               phase_bytes++;
               if (phase_bytes >= RIFF_HDR_BYTES) begin
                  phase = PH_HEADER;
                  phase_bytes = '0;
               end
            end
            PH_HEADER: begin
               if (phase_bytes == 0) begin
                  tag = '0;
                  size = '0;
               end
               if (phase_bytes < 4) tag = {tag[23:0], din};
               else size[8 * phase_bytes[1:0] +: 8] = din;
               phase_bytes++;
               if (phase_bytes >= 8) begin
                  if (tag == TAG_DATA) begin
                     kept_offset = position + 33'd1;
                     kept_length = size;
                     got_data = 1'b1;
                  end
                  if (tag == TAG_FMT) begin
                     foreach (fmt_body[i]) fmt_body[i] = '0;
                     ext_size = '0;
                  end
                  phase = PH_PAYLOAD;
                  phase_bytes = '0;
                  if (size == 0) close_chunk();
               end
            end
            PH_PAYLOAD: begin
               if (tag == TAG_FMT) begin
                  if (phase_bytes < 16) fmt_body[phase_bytes] = din;
                  else if (phase_bytes == 16) ext_size[7:0] = din;
                  else if (phase_bytes == 17) ext_size[15:8] = din;
               end
               phase_bytes++;
               if (phase_bytes == size) close_chunk();
            end
            default: begin
               phase = PH_HEADER;
               phase_bytes = '0;
            end
         endcase
         if (position < (33'd1 << OFFSET_BITS)) position++;

         if (lst) begin
            // ending inside the signature or a payload is a truncated file
            if (phase == PH_RIFF || phase == PH_PAYLOAD) flag(ST_INVAL);
            if (!(got_fmt && got_data)) flag(ST_INVAL);
            res = '0;
            res.status = first_err;
            if (first_err == ST_OK) begin
               res.fmt = kept_fmt;
               res.offset = kept_offset[31:0];
               res.length = kept_length;
            end
            due.push_back(res);
            clear();
         end
      endfunction

      function int waiting();
         return due.size();
      endfunction

      task report(string msg);
         if (mismatches < 60) $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got %0h, expected %0h", name, got, want));
      endtask

      task check_result(status_type st, logic [15:0] chans, logic [31:0] rate,
                        logic [15:0] bits, logic [15:0] align, logic [1:0] code,
                        logic [31:0] offset, logic [31:0] length);
         summary_type want;
         if (due.size() == 0) begin
            report("result arrived with no file pending");
            return;
         end
         want = due.pop_front();
         check_field("status", 32'(st), 32'(want.status));
         check_field("channel_count", 32'(chans), 32'(want.fmt.channels));
         check_field("rate_hz", rate, want.fmt.rate);
         check_field("sample_bits", 32'(bits), 32'(want.fmt.bits));
         check_field("frame_bytes", 32'(align), 32'(want.fmt.align));
         check_field("sample_code", 32'(code), 32'(want.fmt.code));
         check_field("data_offset", offset, want.offset);
         check_field("data_length", length, want.length);
      endtask
   endclass

   wav_scoreboard book;

   // file under construction; send_file streams it and empties it
   logic [7:0] wav_bytes [$];
   logic       calm = 1'b0;      // no gaps and no stalls while set
   int         bytes_sent = 0;
   int         rnd_files = 0;

   // -------------------------------------------------------------------------
   // File builders
   // -------------------------------------------------------------------------
   function automatic void put_be32(logic [31:0] v);
      for (int i = 3; i >= 0; i--) wav_bytes.push_back(v[8 * i +: 8]);
   endfunction

   function automatic void put_le32(logic [31:0] v);
      for (int i = 0; i < 4; i++) wav_bytes.push_back(v[8 * i +: 8]);
   endfunction

   // signature with a random RIFF size field
   function automatic void put_riff_header();
      for (int i = 0; i < 12; i++)
         wav_bytes.push_back((i >= 4 && i < 8) ? 8'($urandom) : RIFF_SIG[95 - 8 * i -: 8]);
   endfunction

   // chunk with random payload and the pad byte after an odd size
   function automatic void put_chunk(logic [31:0] tag, int unsigned len);
      put_be32(tag);
      put_le32(len);
      repeat (len) wav_bytes.push_back(8'($urandom));
      if (len[0]) wav_bytes.push_back(8'($urandom));
   endfunction

   // fmt chunk; channels, rates and align are random, a short size cuts the body
   function automatic void put_fmt(int unsigned len, logic [15:0] fmt_code,
                                   logic [15:0] bits, logic [15:0] ext_len);
      logic [143:0] body;
      body = {ext_len, bits, 16'($urandom), 32'($urandom), 32'($urandom),
              16'($urandom), fmt_code};
      put_be32(TAG_FMT);
      put_le32(len);
      for (int unsigned i = 0; i < len; i++)
         wav_bytes.push_back(i < 18 ? body[8 * i +: 8] : 8'($urandom));
      if (len[0]) wav_bytes.push_back(8'($urandom));
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(logic [7:0] din, logic lst);
      if (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= din;
      req_last_byte <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(din, lst);
      @(negedge clock);
   endtask

   task automatic send_file();
      bytes_sent += wav_bytes.size();
      for (int i = 0; i < wav_bytes.size(); i++)
         send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
      wav_bytes.delete();
   endtask

   // hold off new requests until every pending summary has been checked
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (book.waiting() != 0) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Clock and result side
   // -------------------------------------------------------------------------
   always #5 clock = ~clock;

   always @(negedge clock) rsp_stall <= !calm && ($urandom_range(99) < 6);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result(rsp_status, rsp_channel_count, rsp_rate_hz,
                           rsp_sample_bits, rsp_frame_bytes, rsp_sample_code,
                           rsp_data_offset, rsp_data_length);
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned pick;
      int unsigned cut;
      logic [15:0] bits_ok;
      logic        data_first;

      book = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed files ---
      // a lone byte, then a file one byte short of the signature
      wav_bytes.push_back(8'hFF);
      send_file();
      put_riff_header();
      void'(wav_bytes.pop_back());
      send_file();

      // smallest clean PCM file
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd16, 16'h0000);
      put_chunk(TAG_DATA, 4);
      send_file();

      // extensible, full size, minimum extension
      put_riff_header();
      put_fmt(40, FMT_EXT, 16'd24, EXT_SIZE_MIN);
      put_chunk(TAG_DATA, 0);
      send_file();

      // extensible tag in a plain 16-byte fmt: no extension check
      put_riff_header();
      put_fmt(16, FMT_EXT, 16'd32, 16'h0000);
      put_chunk(TAG_DATA, 1);
      send_file();

      // fmt sizes that are malformed: 17, zero
      put_riff_header();
      put_fmt(FMT_LEN_BAD, FMT_PCM, 16'd16, 16'h0000);
      put_chunk(TAG_DATA, 2);
      send_file();
      put_riff_header();
      put_fmt(0, FMT_PCM, 16'd16, 16'h0000);
      put_chunk(TAG_DATA, 2);
      send_file();

      // extensible with short extension, then with short chunk
      put_riff_header();
      put_fmt(40, FMT_EXT, 16'd16, EXT_SIZE_MIN - 16'd1);
      put_chunk(TAG_DATA, 2);
      send_file();
      put_riff_header();
      put_fmt(39, FMT_EXT, 16'd16, 16'hFFFF);
      put_chunk(TAG_DATA, 2);
      send_file();

      // float format, then 12-bit samples: both unsupported
      put_riff_header();
      put_fmt(16, 16'h0003, 16'd32, 16'h0000);
      put_chunk(TAG_DATA, 2);
      send_file();
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd12, 16'h0000);
      put_chunk(TAG_DATA, 2);
      send_file();

      // odd unknown chunk with pad ahead of fmt, empty data
      put_riff_header();
      put_chunk(TAG_JUNK, 3);
      put_fmt(16, FMT_PCM, 16'd8, 16'h0000);
      put_chunk(TAG_DATA, 0);
      send_file();

      // data payload cut short by the end of file
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd16, 16'h0000);
      put_chunk(TAG_DATA, 8);
      repeat (5) void'(wav_bytes.pop_back());
      send_file();

      // partial chunk header left over at the end is ignored
      put_riff_header();
      put_fmt(18, FMT_PCM, 16'd16, 16'h0000);
      put_chunk(TAG_DATA, 6);
      repeat (3) wav_bytes.push_back(8'h00);
      send_file();

      // odd data with its final pad byte missing
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd24, 16'h0000);
      put_chunk(TAG_DATA, 5);
      void'(wav_bytes.pop_back());
      send_file();

      // no data chunk, then no fmt chunk
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd16, 16'h0000);
      send_file();
      put_riff_header();
      put_chunk(TAG_DATA, 4);
      send_file();

      // a long run with no gaps and no stalls on either side
      calm = 1'b1;

      // bad magic in RIFF, then in WAVE
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd16, 16'h0000);
      put_chunk(TAG_DATA, 2);
      wav_bytes[3] = 8'h58;
      send_file();
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd16, 16'h0000);
      put_chunk(TAG_DATA, 2);
      wav_bytes[11] = 8'h00;
      send_file();

      // two data chunks: the later one is reported
      put_riff_header();
      put_chunk(TAG_DATA, 3);
      put_fmt(16, FMT_PCM, 16'd8, 16'h0000);
      put_chunk(TAG_DATA, 7);
      send_file();

      // good fmt followed by an unsupported one: the error sticks
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd16, 16'h0000);
      put_fmt(16, FMT_PCM, 16'd20, 16'h0000);
      put_chunk(TAG_DATA, 2);
      send_file();

      // all-zero and all-one bytes
      repeat (6) wav_bytes.push_back(8'h00);
      repeat (6) wav_bytes.push_back(8'hFF);
      send_file();

      calm = 1'b0;

      wait_for_results();

      // --- random files ---
      // Mostly well-formed layouts with random content; the rest are noise,
      // broken magic, cut files, bad fmt chunks and missing chunks.
      while (bytes_sent < 1150) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 40)) wav_bytes.push_back(8'($urandom));
         end else begin
            put_riff_header();
            if ($urandom_range(3) == 0)
               put_chunk($urandom, ($urandom_range(99) < 5) ? $urandom_range(200, 400)
                                                          : $urandom_range(0, 9));
            data_first = ($urandom_range(99) < 15);
            if (data_first) put_chunk(TAG_DATA, $urandom_range(0, 9));

            bits_ok = 16'(8 * $urandom_range(1, 4));
            pick = $urandom_range(99);
            if (pick < 55)
               put_fmt($urandom_range(1) ? 16 : 18, FMT_PCM, bits_ok, 16'($urandom));
            else if (pick < 70)
               put_fmt($urandom_range(40, 46), FMT_EXT, bits_ok,
                       16'($urandom_range(22, 65535)));
            else if (pick < 76)
               put_fmt($urandom_range(18, 45), FMT_EXT, bits_ok,
                       16'($urandom_range(0, 30)));
            else if (pick < 80)
               put_fmt($urandom_range(0, 15), FMT_PCM, bits_ok, 16'h0000);
            else if (pick < 83)
               put_fmt(FMT_LEN_BAD, FMT_PCM, bits_ok, 16'h0000);
            else if (pick < 90)
               put_fmt(16, 16'($urandom), bits_ok, 16'h0000);
            else if (pick < 95)
               put_fmt(16, FMT_PCM, 16'($urandom), 16'h0000);
            // else: no fmt chunk is put here, though a later one may still follow

            if ($urandom_range(19) == 0) put_fmt(16, FMT_PCM, bits_ok, 16'h0000);
            if ($urandom_range(9) == 0) put_chunk($urandom, $urandom_range(0, 9));
            if ((!data_first || $urandom_range(3) == 0) && $urandom_range(99) >= 6)
               put_chunk(TAG_DATA, $urandom_range(0, 9));

            // tail: stray header bytes, or the last byte dropped
            pick = $urandom_range(99);
            if (pick < 8) repeat ($urandom_range(1, 7)) wav_bytes.push_back(8'($urandom));
            else if (pick < 13) void'(wav_bytes.pop_back());

            // damage: a magic byte flipped, or the file cut anywhere
            pick = $urandom_range(99);
            if (pick < 6) begin
               cut = $urandom_range(0, 7);
               cut = (cut < 4) ? cut : cut + 4;
               if (cut < wav_bytes.size())
                  wav_bytes[cut] = wav_bytes[cut] ^ 8'($urandom_range(1, 255));
            end else if (pick < 12) begin
               cut = $urandom_range(1, wav_bytes.size());
               while (wav_bytes.size() > cut) void'(wav_bytes.pop_back());
            end
         end
         send_file();
         rnd_files++;
         if (rnd_files == 2) wait_for_results();
      end
      calm = 1'b0;

      // drain, then leave room for any stray result
      wait_for_results();
      repeat (8) @(negedge clock);
      if (book.mismatches == 0 && book.waiting() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
